@@ rtl/core/trefoil_curve_point_and_derivatives_assert.svh @@
// Assertion macros for the trefoil curve evaluator.
// Used by files that check their own control logic; needs i_clk and i_rst_n in scope.
`ifndef TREFOIL_CURVE_POINT_AND_DERIVATIVES_ASSERT_SVH
`define TREFOIL_CURVE_POINT_AND_DERIVATIVES_ASSERT_SVH

// Checked on every rising edge outside reset.
`define TCPD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TCPD_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/tcpd_pkg.sv @@
// Package for the trefoil curve evaluator: constants, types and fixed-point helpers.
// No dependencies; used by the top level and tcpd_trig.
package tcpd_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 20;
    // Compare-and-subtract steps of the modulo 2*pi reduction (quotient below 2^15).
    localparam int RED_STEPS  = 15;
    // Trig latency beyond the CORDIC stages: magnitude, reduction, wrap, fold, output.
    localparam int TRIG_EXTRA = RED_STEPS + 4;

    localparam logic [63:0]        TWO_PI_Q46  = 64'h0001_921F_B544_42D2;
    localparam logic signed [49:0] TWO_PI_W    = 50'sh1_921F_B544_42D2;
    localparam logic signed [49:0] PI_Q46      = 50'sh0_C90F_DAA2_2169;
    localparam logic signed [33:0] PI_Q30      = 34'sh0_C90F_DAA2;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sh0_6487_ED51;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [67:0] LIM33       = 68'sd4294967295;
    localparam logic signed [67:0] SAT_HI      = 68'sd2147483647;
    localparam logic signed [67:0] SAT_LO      = -68'sd2147483648;

    // Register reset values.
    localparam logic signed [31:0] RST_CENTER_X    = 32'sd0;
    localparam logic signed [31:0] RST_CENTER_Y    = 32'sd0;
    localparam logic signed [31:0] RST_FREQ_ONE    = 32'sd21474836;
    localparam logic signed [31:0] RST_FREQ_TWO    = 32'sd32212255;
    localparam logic signed [31:0] RST_BASE_RADIUS = 32'sd10485760;
    localparam logic signed [31:0] RST_LOOP_RADIUS = 32'sd5242880;
    localparam logic signed [31:0] RST_PARAM_SCALE = 32'sd1073741824;

    typedef enum logic [2:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_FREQ_ONE    = 3'd2,
        CFG_FREQ_TWO    = 3'd3,
        CFG_BASE_RADIUS = 3'd4,
        CFG_LOOP_RADIUS = 3'd5,
        CFG_PARAM_SCALE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] slope_x;
        logic [31:0] slope_y;
        logic [31:0] curv_x;
        logic [31:0] curv_y;
    } t_result;

    // Exact product of two 34-bit signed values.
    function automatic logic signed [67:0] mul_full(input logic signed [33:0] a,
                                                    input logic signed [33:0] b);
        return 68'(a) * 68'(b);
    endfunction

    // Product, rounded half up and shifted right by n.
    function automatic logic signed [67:0] mul_rnd(input logic signed [33:0] a,
                                                   input logic signed [33:0] b,
                                                   input int n);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b);
        return (p + (68'sd1 <<< (n - 1))) >>> n;
    endfunction

    // Clamp to +-(2^32 - 1).
    function automatic logic signed [33:0] clamp33(input logic signed [67:0] v);
        if (v > LIM33) begin
            return 34'(LIM33);
        end else if (v < -LIM33) begin
            return 34'(-LIM33);
        end
        return 34'(v);
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [67:0] v);
        if (v > SAT_HI) begin
            return 32'(SAT_HI);
        end else if (v < SAT_LO) begin
            return 32'(SAT_LO);
        end
        return 32'(v);
    endfunction

    // Arctangent of 2^-i in Q.30.
    function automatic logic signed [33:0] arctan_q30(input logic [4:0] i);
        logic signed [33:0] a;
        case (i)
            5'd0:    a = 34'sd843314857;
            5'd1:    a = 34'sd497837829;
            5'd2:    a = 34'sd263043837;
            5'd3:    a = 34'sd133525159;
            5'd4:    a = 34'sd67021687;
            5'd5:    a = 34'sd33543516;
            5'd6:    a = 34'sd16775851;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194283;
            5'd9:    a = 34'sd2097149;
            5'd31:   a = 34'sd0;
            default: a = 34'sd1 <<< (5'd30 - i);
        endcase
        return a;
    endfunction

endpackage

@@ rtl/core/tcpd_if.sv @@
// Handshake interfaces of the trefoil curve evaluator: input items and result items.
// No dependencies.
interface tcpd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] path_param;

    modport source (output valid, output path_param, input ready);
    modport sink   (input valid, input path_param, output ready);
endinterface

interface tcpd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic signed [31:0] curv_x;
    logic signed [31:0] curv_y;

    modport source (output valid, output pos_x, output pos_y, output slope_x,
                    output slope_y, output curv_x, output curv_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input slope_x,
                    input slope_y, input curv_x, input curv_y, output ready);
endinterface

@@ rtl/core/trefoil_curve_point_and_derivatives.sv @@
// Top level of the trefoil curve evaluator: configuration, product pipeline, output skid.
// Depends on tcpd_pkg, tcpd_if, tcpd_trig and the assertion header.
//
//  channel   direction  contents
//  i_in      in         path_param (Q16.16)
//  o_res     out        pos_x, pos_y, slope_x, slope_y (Q16.16); curv_x, curv_y (Q8.24)
//  i_cfg_*   in         write enable, register index, 32-bit data
//
// One item is accepted per cycle while the skid is free; each result passes through
// the 15 reduction stages and the CORDIC stages of the two trig lanes.
// Reset is synchronous and clears the valid bits and loads the register defaults.
// A stalled result moves into a one-entry skid; the whole pipeline holds only
// while that skid is occupied, and input ready falls for exactly that time.
`include "trefoil_curve_point_and_derivatives_assert.svh"

module trefoil_curve_point_and_derivatives #(
    parameter int CORDIC_ITERATIONS = tcpd_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    tcpd_in_if.sink     i_in,
    tcpd_out_if.source  o_res
);

    localparam int TRIG_LAT = CORDIC_ITERATIONS + tcpd_pkg::TRIG_EXTRA;
    localparam int NSTG     = TRIG_LAT + 9;

    logic signed [31:0] r_cx, r_cy, r_f1, r_f2, r_base, r_loop, r_scale;
    logic [NSTG-1:0]    r_vld;
    logic               w_en;
    logic               w_take;

    logic signed [31:0] r_w;
    logic signed [33:0] r_sp;
    logic signed [63:0] r_a1, r_a2;
    logic signed [33:0] w_ca, w_sa, w_cb, w_sb;
    logic signed [33:0] r_rc, r_rs, r_ca1, r_sa1;
    logic signed [33:0] r_amp, r_rc2, r_rs2, r_ca2, r_sa2;
    logic signed [35:0] r_pc, r_ps;
    logic signed [33:0] r_cbt, r_sbt, r_crc, r_src;
    logic signed [33:0] w_pcc, w_psc;
    logic [31:0]        r_px4, r_py4, r_px5, r_py5, r_sx5, r_sy5;
    logic signed [35:0] r_q1, r_q2, r_q3, r_q4, r_q5, r_q6;
    logic signed [43:0] r_e1, r_e2, r_e3, r_e4, r_e5, r_e6;
    tcpd_pkg::t_result  r_last, r_out, r_skid;
    logic               r_out_vld, r_skid_vld;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= tcpd_pkg::RST_CENTER_X;
            r_cy    <= tcpd_pkg::RST_CENTER_Y;
            r_f1    <= tcpd_pkg::RST_FREQ_ONE;
            r_f2    <= tcpd_pkg::RST_FREQ_TWO;
            r_base  <= tcpd_pkg::RST_BASE_RADIUS;
            r_loop  <= tcpd_pkg::RST_LOOP_RADIUS;
            r_scale <= tcpd_pkg::RST_PARAM_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcpd_pkg::CFG_CENTER_X:    r_cx    <= i_cfg_data;
                tcpd_pkg::CFG_CENTER_Y:    r_cy    <= i_cfg_data;
                tcpd_pkg::CFG_FREQ_ONE:    r_f1    <= i_cfg_data;
                tcpd_pkg::CFG_FREQ_TWO:    r_f2    <= i_cfg_data;
                tcpd_pkg::CFG_BASE_RADIUS: r_base  <= i_cfg_data;
                tcpd_pkg::CFG_LOOP_RADIUS: r_loop  <= i_cfg_data;
                tcpd_pkg::CFG_PARAM_SCALE: r_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the skid is free.
    assign w_en       = !r_skid_vld;
    assign w_take     = r_out_vld && o_res.ready;
    assign i_in.ready = w_en;

    // Valid bits travel alongside the stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    // Input register, scaled parameter and the two angles in Q.46.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w  <= i_in.path_param;
            r_sp <= tcpd_pkg::clamp33(tcpd_pkg::mul_rnd(34'(r_w), 34'(r_scale), 30));
            r_a1 <= 64'(tcpd_pkg::mul_full(r_sp, 34'(r_f1)));
            r_a2 <= 64'(tcpd_pkg::mul_full(r_sp, 34'(r_f2)));
        end
    end

    tcpd_trig #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_trig_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_a1),
        .o_cos (w_ca),
        .o_sin (w_sa)
    );

    tcpd_trig #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_trig_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_a2),
        .o_cos (w_cb),
        .o_sin (w_sb)
    );

    assign w_pcc = tcpd_pkg::clamp33(68'(r_pc));
    assign w_psc = tcpd_pkg::clamp33(68'(r_ps));

    // Radius terms, amplitude, then the products with the first sine and cosine.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rc  <= tcpd_pkg::clamp33(tcpd_pkg::mul_rnd(34'(r_loop), w_cb, 30));
            r_rs  <= tcpd_pkg::clamp33(tcpd_pkg::mul_rnd(34'(r_loop), w_sb, 30));
            r_ca1 <= w_ca;
            r_sa1 <= w_sa;

            r_amp <= tcpd_pkg::clamp33(68'(r_rc) + 68'(r_base));
            r_rc2 <= r_rc;
            r_rs2 <= r_rs;
            r_ca2 <= r_ca1;
            r_sa2 <= r_sa1;

            r_pc  <= 36'(tcpd_pkg::mul_rnd(r_ca2, r_amp, 30));
            r_ps  <= 36'(tcpd_pkg::mul_rnd(r_sa2, r_amp, 30));
            r_cbt <= tcpd_pkg::clamp33(tcpd_pkg::mul_rnd(r_ca2, r_rs2, 30));
            r_sbt <= tcpd_pkg::clamp33(tcpd_pkg::mul_rnd(r_sa2, r_rs2, 30));
            r_crc <= tcpd_pkg::clamp33(tcpd_pkg::mul_rnd(r_ca2, r_rc2, 30));
            r_src <= tcpd_pkg::clamp33(tcpd_pkg::mul_rnd(r_sa2, r_rc2, 30));
        end
    end

    // Position, frequency products, then the derivative sums.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px4 <= tcpd_pkg::sat32(68'(r_pc) + 68'(r_cx));
            r_py4 <= tcpd_pkg::sat32(68'(r_ps) + 68'(r_cy));
            r_q1  <= 36'(tcpd_pkg::mul_rnd(34'(r_f1), w_psc, 30));
            r_q2  <= 36'(tcpd_pkg::mul_rnd(34'(r_f2), r_cbt, 30));
            r_q3  <= 36'(tcpd_pkg::mul_rnd(34'(r_f1), w_pcc, 30));
            r_q4  <= 36'(tcpd_pkg::mul_rnd(34'(r_f2), r_sbt, 30));
            r_q5  <= 36'(tcpd_pkg::mul_rnd(34'(r_f2), r_crc, 30));
            r_q6  <= 36'(tcpd_pkg::mul_rnd(34'(r_f2), r_src, 30));

            r_px5 <= r_px4;
            r_py5 <= r_py4;
            r_sx5 <= tcpd_pkg::sat32(-68'(r_q1) - 68'(r_q2));
            r_sy5 <= tcpd_pkg::sat32(68'(r_q3) - 68'(r_q4));
            r_e1  <= 44'(tcpd_pkg::mul_rnd(34'(r_f1), tcpd_pkg::clamp33(68'(r_q3)), 22));
            r_e2  <= 44'(tcpd_pkg::mul_rnd(34'(r_f1), tcpd_pkg::clamp33(68'(r_q4)), 22));
            r_e3  <= 44'(tcpd_pkg::mul_rnd(34'(r_f2), tcpd_pkg::clamp33(68'(r_q5)), 22));
            r_e4  <= 44'(tcpd_pkg::mul_rnd(34'(r_f1), tcpd_pkg::clamp33(68'(r_q1)), 22));
            r_e5  <= 44'(tcpd_pkg::mul_rnd(34'(r_f1), tcpd_pkg::clamp33(68'(r_q2)), 22));
            r_e6  <= 44'(tcpd_pkg::mul_rnd(34'(r_f2), tcpd_pkg::clamp33(68'(r_q6)), 22));

            r_last.pos_x   <= r_px5;
            r_last.pos_y   <= r_py5;
            r_last.slope_x <= r_sx5;
            r_last.slope_y <= r_sy5;
            r_last.curv_x  <= tcpd_pkg::sat32(-68'(r_e1) + (68'(r_e2) <<< 1) - 68'(r_e3));
            r_last.curv_y  <= tcpd_pkg::sat32(-68'(r_e4) - (68'(r_e5) <<< 1) - 68'(r_e6));
        end
    end

    // Output register with a one-item skid behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || w_take) begin
            r_out_vld <= r_vld[NSTG-1];
        end else if (r_vld[NSTG-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || w_take) begin
            r_out <= r_last;
        end else begin
            r_skid <= r_last;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.pos_x   = r_out.pos_x;
    assign o_res.pos_y   = r_out.pos_y;
    assign o_res.slope_x = r_out.slope_x;
    assign o_res.slope_y = r_out.slope_y;
    assign o_res.curv_x  = r_out.curv_x;
    assign o_res.curv_y  = r_out.curv_y;

    // Control checks on the output side.
    `TCPD_ASSERT_RST(a_skid_needs_out, r_skid_vld |-> r_out_vld, "skid item without output item")
    `TCPD_ASSERT_RST(a_result_kept, r_out_vld && !o_res.ready |=> r_out_vld, "stalled item lost")
    `TCPD_ASSERT_RST(a_skid_on_stall, $rose(r_skid_vld) |-> $past(r_out_vld && !o_res.ready), "skid filled without a stall")
    `TCPD_ASSERT_CLK(a_reset_clears, !i_rst_n |=> !r_out_vld && !r_skid_vld, "reset left an item")

endmodule

@@ rtl/core/tcpd_trig.sv @@
// Pipelined cosine and sine of a Q.46 angle: modulo 2*pi reduction, fold, CORDIC.
// Depends on tcpd_pkg.
module tcpd_trig #(
    parameter int CORDIC_ITERATIONS = tcpd_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_ang,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);

    localparam int RED  = tcpd_pkg::RED_STEPS;
    localparam int ITER = CORDIC_ITERATIONS;

    logic [63:0]        r_mag [0:RED];
    logic               r_neg [0:RED];
    logic signed [33:0] r_z1;
    logic signed [33:0] r_cx [1:ITER];
    logic signed [33:0] r_cy [1:ITER];
    logic signed [33:0] r_cz [0:ITER];
    logic               r_cf [0:ITER];
    logic signed [33:0] c_x [0:ITER];
    logic signed [33:0] c_y [0:ITER];
    logic signed [33:0] r_cos;
    logic signed [33:0] r_sin;
    logic signed [49:0] c_rem;
    logic signed [49:0] c_wrap;
    logic signed [50:0] c_rnd;

    // Split the angle into sign and magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0] <= i_ang[63] ? $unsigned(-i_ang) : $unsigned(i_ang);
            r_neg[0] <= i_ang[63];
        end
    end

    // Restoring reduction of the magnitude, one power-of-two multiple of 2*pi per stage, largest first.
    for (genvar j = 1; j <= RED; j++) begin : g_red
        localparam logic [63:0] SUB = tcpd_pkg::TWO_PI_Q46 << (RED - j);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mag[j] <= (r_mag[j-1] >= SUB) ? r_mag[j-1] - SUB : r_mag[j-1];
                r_neg[j] <= r_neg[j-1];
            end
        end
    end

    // Restore the sign, wrap into [-pi, pi] and round to Q.30.
    always_comb begin
        c_rem = $signed({1'b0, r_mag[RED][48:0]});
        if (r_neg[RED]) begin
            c_rem = -c_rem;
        end
        c_wrap = c_rem;
        if (c_rem > tcpd_pkg::PI_Q46) begin
            c_wrap = c_rem - tcpd_pkg::TWO_PI_W;
        end else if (c_rem < -tcpd_pkg::PI_Q46) begin
            c_wrap = c_rem + tcpd_pkg::TWO_PI_W;
        end
        c_rnd = 51'(c_wrap) + 51'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1 <= 34'(c_rnd >>> 16);
        end
    end

    // Fold into [-pi/2, pi/2]; the flip negates both results at the end.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_z1 > tcpd_pkg::HALF_PI_Q30) begin
                r_cz[0] <= r_z1 - tcpd_pkg::PI_Q30;
                r_cf[0] <= 1'b1;
            end else if (r_z1 < -tcpd_pkg::HALF_PI_Q30) begin
                r_cz[0] <= r_z1 + tcpd_pkg::PI_Q30;
                r_cf[0] <= 1'b1;
            end else begin
                r_cz[0] <= r_z1;
                r_cf[0] <= 1'b0;
            end
        end
    end

    // The rotation starts from the fixed gain on the x axis.
    assign c_x[0] = tcpd_pkg::GAIN_Q30;
    assign c_y[0] = 34'sd0;
    for (genvar i = 1; i <= ITER; i++) begin : g_tap
        assign c_x[i] = r_cx[i];
        assign c_y[i] = r_cy[i];
    end

    // One CORDIC rotation per stage.
    for (genvar i = 0; i < ITER; i++) begin : g_cordic
        localparam logic signed [33:0] ATAN = tcpd_pkg::arctan_q30(5'(i));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cz[i][33]) begin
                    r_cx[i+1] <= c_x[i] - (c_y[i] >>> i);
                    r_cy[i+1] <= c_y[i] + (c_x[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - ATAN;
                end else begin
                    r_cx[i+1] <= c_x[i] + (c_y[i] >>> i);
                    r_cy[i+1] <= c_y[i] - (c_x[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + ATAN;
                end
                r_cf[i+1] <= r_cf[i];
            end
        end
    end

    // Undo the fold.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_cf[ITER] ? -c_x[ITER] : c_x[ITER];
            r_sin <= r_cf[ITER] ? -c_y[ITER] : c_y[ITER];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule
